>>> design/rse_pkg.sv
package rse_pkg;

    localparam int KIND_BITS   = 3;
    localparam int REG_BITS    = 6;
    localparam int CYCLE_BITS  = 32;
    localparam int TICK_BITS   = 8;
    localparam int ACTION_BITS = 2;
    localparam int PHASE_BITS  = 3;
    localparam int CFG_BITS    = 8;

    localparam logic [KIND_BITS-1:0] KIND_ISSUE     = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_BROADCAST = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_START_EX  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_TICK      = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_START_WR  = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_WR_STEP   = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_WR_ACK    = 3'd6;

    localparam logic [PHASE_BITS-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_WAIT   = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_READY  = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_EXEC   = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_EXDONE = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_WRITE  = 3'd5;
    localparam logic [PHASE_BITS-1:0] PH_WRDONE = 3'd6;

    localparam logic [ACTION_BITS-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_BUS   = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_STORE = 2'd3;

    localparam logic [REG_BITS-1:0] NO_REG = 6'd32;

    localparam logic CFG_EXEC_CYCLES = 1'b0;

    typedef struct packed {
        logic [PHASE_BITS-1:0]  phase;
        logic                   one_rdy;
        logic                   two_rdy;
        logic [TICK_BITS-1:0]   ticks;
        logic [ACTION_BITS-1:0] action;
    } t_ctl;

    typedef struct packed {
        logic args_ready;
        logic bus_request;
        logic store_request;
    } t_flags;

endpackage

>>> design/reservation_station_entry.sv
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_kind .. i_unit_value
// out     | output    | o_out_valid / i_out_ready  | o_phase .. o_start_cycle
// cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// Input beat to result beat: input register, then the entry state, which
// doubles as the result register. One beat per cycle, unless the output
// stalls; the state update logic between the two registers sets that.
// Synchronous active-low reset returns the entry to idle with exec_cycles 1.
// A stalled output holds the state; the input register still takes one beat.
module reservation_station_entry #(
    parameter int DATA_BITS = 32,
    parameter int TAG_BITS  = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [rse_pkg::CFG_BITS-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rse_pkg::KIND_BITS-1:0]   i_kind,
    input  logic [TAG_BITS-1:0]             i_src1_tag,
    input  logic [DATA_BITS-1:0]            i_src1_value,
    input  logic [TAG_BITS-1:0]             i_src2_tag,
    input  logic [DATA_BITS-1:0]            i_src2_value,
    input  logic [rse_pkg::ACTION_BITS-1:0] i_write_action,
    input  logic [rse_pkg::REG_BITS-1:0]    i_dest_reg,
    input  logic [rse_pkg::CYCLE_BITS-1:0]  i_issue_clock,
    input  logic [TAG_BITS-1:0]             i_bus_tag,
    input  logic [DATA_BITS-1:0]            i_bus_value,
    input  logic [DATA_BITS-1:0]            i_unit_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rse_pkg::PHASE_BITS-1:0]  o_phase,
    output logic [DATA_BITS-1:0]            o_operand_one,
    output logic [DATA_BITS-1:0]            o_operand_two,
    output logic [DATA_BITS-1:0]            o_result_value,
    output logic [TAG_BITS-1:0]             o_wait_tag_one,
    output logic [TAG_BITS-1:0]             o_wait_tag_two,
    output logic                            o_args_ready,
    output logic                            o_bus_request,
    output logic                            o_store_request,
    output logic [rse_pkg::REG_BITS-1:0]    o_rename_reg,
    output logic                            o_unrename,
    output logic [rse_pkg::CYCLE_BITS-1:0]  o_start_cycle
);

    logic [rse_pkg::TICK_BITS-1:0] r_exec_cycles;

    logic                            r_in_vld;
    logic [rse_pkg::KIND_BITS-1:0]   r_kind;
    logic [TAG_BITS-1:0]             r_src1_tag;
    logic [DATA_BITS-1:0]            r_src1_value;
    logic [TAG_BITS-1:0]             r_src2_tag;
    logic [DATA_BITS-1:0]            r_src2_value;
    logic [rse_pkg::ACTION_BITS-1:0] r_write_action;
    logic [rse_pkg::REG_BITS-1:0]    r_dest_reg;
    logic [rse_pkg::CYCLE_BITS-1:0]  r_issue_clock;
    logic [TAG_BITS-1:0]             r_bus_tag;
    logic [DATA_BITS-1:0]            r_bus_value;
    logic [DATA_BITS-1:0]            r_unit_value;

    logic                            r_out_vld;
    rse_pkg::t_ctl                   r_ctl;
    logic [DATA_BITS-1:0]            r_op_one;
    logic [DATA_BITS-1:0]            r_op_two;
    logic [TAG_BITS-1:0]             r_wait_one;
    logic [TAG_BITS-1:0]             r_wait_two;
    logic [DATA_BITS-1:0]            r_result;
    logic [rse_pkg::CYCLE_BITS-1:0]  r_start_cycle;
    rse_pkg::t_flags                 r_flags;
    logic [rse_pkg::REG_BITS-1:0]    r_rename_reg;

    rse_pkg::t_ctl                   n_ctl;
    logic [DATA_BITS-1:0]            n_op_one;
    logic [DATA_BITS-1:0]            n_op_two;
    logic [TAG_BITS-1:0]             n_wait_one;
    logic [TAG_BITS-1:0]             n_wait_two;
    logic [DATA_BITS-1:0]            n_result;
    logic [rse_pkg::CYCLE_BITS-1:0]  n_start_cycle;
    rse_pkg::t_flags                 n_flags;
    logic [rse_pkg::REG_BITS-1:0]    n_rename_reg;

    logic advance;
    logic in_take;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_take    = i_in_valid && o_in_ready;

    // station tag is implied in rename and bus requests; nothing to hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec_cycles <= rse_pkg::TICK_BITS'(1);
        end else if (i_cfg_we && (i_cfg_idx == rse_pkg::CFG_EXEC_CYCLES)) begin
            r_exec_cycles <= i_cfg_data[rse_pkg::TICK_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind         <= i_kind;
            r_src1_tag     <= i_src1_tag;
            r_src1_value   <= i_src1_value;
            r_src2_tag     <= i_src2_tag;
            r_src2_value   <= i_src2_value;
            r_write_action <= i_write_action;
            r_dest_reg     <= i_dest_reg;
            r_issue_clock  <= i_issue_clock;
            r_bus_tag      <= i_bus_tag;
            r_bus_value    <= i_bus_value;
            r_unit_value   <= i_unit_value;
        end
    end

    rse_step #(
        .DATA_BITS (DATA_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_step (
        .i_kind         (r_kind),
        .i_src1_tag     (r_src1_tag),
        .i_src1_value   (r_src1_value),
        .i_src2_tag     (r_src2_tag),
        .i_src2_value   (r_src2_value),
        .i_write_action (r_write_action),
        .i_dest_reg     (r_dest_reg),
        .i_issue_clock  (r_issue_clock),
        .i_bus_tag      (r_bus_tag),
        .i_bus_value    (r_bus_value),
        .i_unit_value   (r_unit_value),
        .i_exec_cycles  (r_exec_cycles),
        .i_ctl          (r_ctl),
        .i_op_one       (r_op_one),
        .i_op_two       (r_op_two),
        .i_wait_one     (r_wait_one),
        .i_wait_two     (r_wait_two),
        .i_result       (r_result),
        .i_start_cycle  (r_start_cycle),
        .o_ctl          (n_ctl),
        .o_op_one       (n_op_one),
        .o_op_two       (n_op_two),
        .o_wait_one     (n_wait_one),
        .o_wait_two     (n_wait_two),
        .o_result       (n_result),
        .o_start_cycle  (n_start_cycle),
        .o_flags        (n_flags),
        .o_rename_reg   (n_rename_reg)
    );

    // entry state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld     <= 1'b0;
            r_ctl         <= '{phase: rse_pkg::PH_IDLE, default: '0};
            r_op_one      <= '0;
            r_op_two      <= '0;
            r_wait_one    <= '0;
            r_wait_two    <= '0;
            r_result      <= '0;
            r_start_cycle <= '0;
            r_flags       <= '0;
            r_rename_reg  <= rse_pkg::NO_REG;
        end else if (advance) begin
            r_out_vld     <= 1'b1;
            r_ctl         <= n_ctl;
            r_op_one      <= n_op_one;
            r_op_two      <= n_op_two;
            r_wait_one    <= n_wait_one;
            r_wait_two    <= n_wait_two;
            r_result      <= n_result;
            r_start_cycle <= n_start_cycle;
            r_flags       <= n_flags;
            r_rename_reg  <= n_rename_reg;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_phase         = r_ctl.phase;
    assign o_operand_one   = r_op_one;
    assign o_operand_two   = r_op_two;
    assign o_result_value  = r_result;
    assign o_wait_tag_one  = r_wait_one;
    assign o_wait_tag_two  = r_wait_two;
    assign o_args_ready    = r_flags.args_ready;
    assign o_bus_request   = r_flags.bus_request;
    assign o_store_request = r_flags.store_request;
    assign o_rename_reg    = r_rename_reg;
    assign o_unrename      = 1'b0;
    assign o_start_cycle   = r_start_cycle;

    a_store_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.store_request |-> (r_ctl.phase == rse_pkg::PH_WRDONE))
        else $error("store beat outside write done");

    a_bus_writing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.bus_request |-> (r_ctl.phase == rse_pkg::PH_WRITE))
        else $error("bus request outside writing");

    a_args_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.args_ready |-> (r_ctl.phase == rse_pkg::PH_READY) && r_ctl.one_rdy
                               && r_ctl.two_rdy)
        else $error("args ready without both operands");

    a_tags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.phase != rse_pkg::PH_WAIT) |-> (r_wait_one == '0) && (r_wait_two == '0))
        else $error("tag still awaited outside waiting");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_out_ready) |=> r_in_vld)
        else $error("held beat dropped under stall");

endmodule

>>> design/rse_step.sv
module rse_step #(
    parameter int DATA_BITS = 32,
    parameter int TAG_BITS  = 4
) (
    input  logic [rse_pkg::KIND_BITS-1:0]   i_kind,
    input  logic [TAG_BITS-1:0]             i_src1_tag,
    input  logic [DATA_BITS-1:0]            i_src1_value,
    input  logic [TAG_BITS-1:0]             i_src2_tag,
    input  logic [DATA_BITS-1:0]            i_src2_value,
    input  logic [rse_pkg::ACTION_BITS-1:0] i_write_action,
    input  logic [rse_pkg::REG_BITS-1:0]    i_dest_reg,
    input  logic [rse_pkg::CYCLE_BITS-1:0]  i_issue_clock,
    input  logic [TAG_BITS-1:0]             i_bus_tag,
    input  logic [DATA_BITS-1:0]            i_bus_value,
    input  logic [DATA_BITS-1:0]            i_unit_value,
    input  logic [rse_pkg::TICK_BITS-1:0]   i_exec_cycles,
    input  rse_pkg::t_ctl                   i_ctl,
    input  logic [DATA_BITS-1:0]            i_op_one,
    input  logic [DATA_BITS-1:0]            i_op_two,
    input  logic [TAG_BITS-1:0]             i_wait_one,
    input  logic [TAG_BITS-1:0]             i_wait_two,
    input  logic [DATA_BITS-1:0]            i_result,
    input  logic [rse_pkg::CYCLE_BITS-1:0]  i_start_cycle,
    output rse_pkg::t_ctl                   o_ctl,
    output logic [DATA_BITS-1:0]            o_op_one,
    output logic [DATA_BITS-1:0]            o_op_two,
    output logic [TAG_BITS-1:0]             o_wait_one,
    output logic [TAG_BITS-1:0]             o_wait_two,
    output logic [DATA_BITS-1:0]            o_result,
    output logic [rse_pkg::CYCLE_BITS-1:0]  o_start_cycle,
    output rse_pkg::t_flags                 o_flags,
    output logic [rse_pkg::REG_BITS-1:0]    o_rename_reg
);

    logic hit_one;
    logic hit_two;
    logic one_now;
    logic two_now;

    assign hit_one = !i_ctl.one_rdy && (i_bus_tag != '0) && (i_bus_tag == i_wait_one);
    assign hit_two = !i_ctl.two_rdy && (i_bus_tag != '0) && (i_bus_tag == i_wait_two);
    assign one_now = i_ctl.one_rdy || hit_one;
    assign two_now = i_ctl.two_rdy || hit_two;

    always_comb begin
        o_ctl         = i_ctl;
        o_op_one      = i_op_one;
        o_op_two      = i_op_two;
        o_wait_one    = i_wait_one;
        o_wait_two    = i_wait_two;
        o_result      = i_result;
        o_start_cycle = i_start_cycle;
        o_flags       = '0;
        o_rename_reg  = rse_pkg::NO_REG;
        case (i_kind)
            rse_pkg::KIND_ISSUE: begin
                o_start_cycle = i_issue_clock;
                o_ctl.ticks   = i_exec_cycles;
                o_ctl.action  = i_write_action;
                o_result      = '0;
                o_ctl.one_rdy = (i_src1_tag == '0);
                o_ctl.two_rdy = (i_src2_tag == '0);
                o_wait_one    = i_src1_tag;
                o_wait_two    = i_src2_tag;
                o_op_one      = (i_src1_tag == '0) ? i_src1_value : '0;
                o_op_two      = (i_src2_tag == '0) ? i_src2_value : '0;
                o_ctl.phase   = ((i_src1_tag == '0) && (i_src2_tag == '0)) ?
                                rse_pkg::PH_READY : rse_pkg::PH_WAIT;
                if ((i_dest_reg != '0) && (i_dest_reg < rse_pkg::NO_REG)) begin
                    o_rename_reg = i_dest_reg;
                end
            end
            rse_pkg::KIND_BROADCAST: begin
                if (i_ctl.phase == rse_pkg::PH_WAIT) begin
                    if (hit_one) begin
                        o_op_one      = i_bus_value;
                        o_ctl.one_rdy = 1'b1;
                        o_wait_one    = '0;
                    end
                    if (hit_two) begin
                        o_op_two      = i_bus_value;
                        o_ctl.two_rdy = 1'b1;
                        o_wait_two    = '0;
                    end
                    if (one_now && two_now) begin
                        o_ctl.phase        = rse_pkg::PH_READY;
                        o_flags.args_ready = 1'b1;
                    end
                end
            end
            rse_pkg::KIND_START_EX: begin
                if (i_ctl.phase == rse_pkg::PH_READY) begin
                    o_ctl.phase = rse_pkg::PH_EXEC;
                end
            end
            rse_pkg::KIND_TICK: begin
                if (i_ctl.phase == rse_pkg::PH_EXEC) begin
                    if (i_ctl.ticks <= rse_pkg::TICK_BITS'(1)) begin
                        o_ctl.ticks = '0;
                        o_result    = i_unit_value;
                        o_ctl.phase = rse_pkg::PH_EXDONE;
                    end else begin
                        o_ctl.ticks = i_ctl.ticks - rse_pkg::TICK_BITS'(1);
                    end
                end
            end
            rse_pkg::KIND_START_WR: begin
                if (i_ctl.phase == rse_pkg::PH_EXDONE) begin
                    o_ctl.phase = rse_pkg::PH_WRITE;
                end
            end
            rse_pkg::KIND_WR_STEP: begin
                if (i_ctl.phase == rse_pkg::PH_WRITE) begin
                    case (i_ctl.action)
                        rse_pkg::ACT_NONE: begin
                            o_ctl.phase = rse_pkg::PH_WRDONE;
                        end
                        rse_pkg::ACT_BUS: begin
                            o_flags.bus_request = 1'b1;
                        end
                        rse_pkg::ACT_STORE: begin
                            o_flags.store_request = 1'b1;
                            o_ctl.phase           = rse_pkg::PH_WRDONE;
                        end
                        default: begin
                            // program counter write: hold in writing
                        end
                    endcase
                end
            end
            rse_pkg::KIND_WR_ACK: begin
                if (i_ctl.phase == rse_pkg::PH_WRITE) begin
                    o_ctl.phase = rse_pkg::PH_WRDONE;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
